>>> sv/evma_pkg.sv
// evma_pkg: shared constants, types and request structs for the encoder
// velocity moving-average block. No dependencies.
package evma_pkg;

  localparam int WINDOW   = 10;
  localparam int COUNT_W  = 32;
  localparam int SCALE_W  = 24;
  localparam int PROD_W   = COUNT_W + SCALE_W;
  localparam int SAMPLE_W = 48;
  localparam int SUM_W    = 55;
  localparam int MAG_W    = SUM_W - 1;
  localparam int FILL_W   = 7;
  localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W    = $clog2(MAG_W);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(WINDOW);
  localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(MAG_W - 1);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_ADD,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                       we;
    logic signed [SAMPLE_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [FILL_W-1:0]       divisor;
  } div_req_t;

endpackage

>>> sv/evma_ring.sv
// evma_ring: sample ring memory with its write pointer; the entry at the
// pointer (the oldest sample once full) is read every cycle. Uses evma_pkg.
module evma_ring (
  input  logic                                clk,
  input  logic                                rst_n,
  input  evma_pkg::ring_req_t                 req,
  output logic signed [evma_pkg::SAMPLE_W-1:0] old_sample
);
  import evma_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW];
  logic [PTR_W-1:0]           ptr_r, ptr_nxt;
  logic signed [SAMPLE_W-1:0] rd_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (req.we) begin
      ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[ptr_r] <= req.wdata;
    end
    rd_r <= mem[ptr_r];
  end

  assign old_sample = rd_r;

endmodule

>>> sv/evma_div.sv
// evma_div: restoring divider, one quotient bit per cycle, signed
// dividend by small unsigned divisor, truncating toward zero. Uses evma_pkg.
module evma_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  evma_pkg::div_req_t                  req,
  output logic                                done,
  output logic signed [evma_pkg::SAMPLE_W-1:0] quotient
);
  import evma_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0]    quo_r, quo_nxt;
  logic [FILL_W-1:0]   rem_r, rem_nxt;
  logic [FILL_W-1:0]   dvs_r, dvs_nxt;
  logic                neg_r, neg_nxt;
  logic [SUM_W-1:0]    abs_sum;
  logic [FILL_W:0]     rem_sh;
  logic [FILL_W:0]     rem_diff;
  logic [MAG_W-1:0]    q_signed;

  always_comb begin
    abs_sum  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    rem_sh   = {rem_r, quo_r[MAG_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_LAST;
      quo_nxt  = abs_sum[MAG_W-1:0];
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      neg_nxt  = req.dividend[SUM_W-1];
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_diff[FILL_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[FILL_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? -quo_r : quo_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

endmodule

>>> sv/encoder_velocity_moving_average.sv
// Encoder velocity moving average: each request carries an absolute encoder
// count; the wrapped count step times the configured scale, saturated to 48 bits, goes
// into a ring of the last 10 samples and the mean of the held samples comes
// out with the fill count. A request runs through the 54-step restoring
// divider that forms the mean one bit per cycle; the next request is taken
// once the divide is done and the result is loaded into the output register,
// which may still wait on out_ready meanwhile.
// Uses evma_pkg, evma_ring and evma_div.
module encoder_velocity_moving_average (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [evma_pkg::SCALE_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [evma_pkg::COUNT_W-1:0]  in_encoder_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [evma_pkg::SAMPLE_W-1:0] out_average_speed,
  output logic [evma_pkg::FILL_W-1:0]          out_window_fill
);
  import evma_pkg::*;

  state_t                     state_r, state_nxt;
  logic [SCALE_W-1:0]         scale_r;
  logic [COUNT_W-1:0]         prev_r;
  logic signed [COUNT_W-1:0]  diff_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [FILL_W-1:0]          held_r, held_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_avg_r;
  logic [FILL_W-1:0]          out_fill_r;
  logic                       accept;
  logic                       load_out;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] quotient;
  logic                       div_done;
  ring_req_t                  ring_req;
  div_req_t                   div_req;

  evma_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ring_req),
    .old_sample (old_sample)
  );

  evma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // saturate the 56-bit product to the 48-bit sample range
  always_comb begin
    if (!prod_r[PROD_W-1] && (prod_r[PROD_W-2:SAMPLE_W-1] != '0)) begin
      sat_sample = SAMPLE_MAX;
    end else if (prod_r[PROD_W-1] && (prod_r[PROD_W-2:SAMPLE_W-1] != '1)) begin
      sat_sample = SAMPLE_MIN;
    end else begin
      sat_sample = prod_r[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    sum_nxt          = sum_r;
    held_nxt         = held_r;
    out_valid_nxt    = out_valid_r;
    load_out         = 1'b0;
    ring_req.we      = 1'b0;
    ring_req.wdata   = sat_sample;
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = held_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        ring_req.we = 1'b1;
        if (held_r >= FILL_FULL) begin
          sum_nxt = sum_r - SUM_W'(old_sample);
        end else begin
          held_nxt = held_r + FILL_W'(1);
        end
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        sum_nxt   = sum_r + SUM_W'(sample_r);
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scale_r     <= SCALE_RESET;
      prev_r      <= '0;
      sum_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (accept) begin
        prev_r <= in_encoder_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r <= in_encoder_count - prev_r;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(diff_r) * PROD_W'($signed({1'b0, scale_r}));
    end
    if (state_r == ST_SUB) begin
      sample_r <= sat_sample;
    end
    if (load_out) begin
      out_avg_r  <= quotient;
      out_fill_r <= held_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_average_speed = out_avg_r;
  assign out_window_fill   = out_fill_r;

endmodule
